>>> sv/casd_pkg.sv
// constants and types shared by the arithmetic symbol decoder
// no dependencies
package casd_pkg;

	localparam int CODE_BITS    = 32;
	localparam int FREQ_BITS    = 16;
	localparam int NUM_SYMBOLS  = 257;
	localparam int NUM_CONTEXTS = 256;

	localparam int ROW_LEN    = NUM_SYMBOLS + 1;
	localparam int TABLE_SIZE = NUM_CONTEXTS * ROW_LEN;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);

	// range is one bit wider than a bound, product adds a frequency word
	localparam int RANGE_W = CODE_BITS + 1;
	localparam int PROD_W  = RANGE_W + FREQ_BITS;

	localparam logic [CODE_BITS-1:0] HALF_PT = CODE_BITS'(1) << (CODE_BITS - 1);
	localparam logic [CODE_BITS-1:0] QTR1_PT = HALF_PT >> 1;
	localparam logic [CODE_BITS-1:0] QTR3_PT = HALF_PT + QTR1_PT;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_INIT   = 2'd1;
	localparam logic [1:0] KIND_DECODE = 2'd2;

	localparam logic [8:0] EOF_RESET = 9'd257;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [FREQ_BITS-1:0] freq_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic [RANGE_W-1:0]   range_t;

	// divider handshake between sequencer and divider
	typedef struct packed {
		logic   start;
		prod_t  dividend;
		range_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		prod_t quotient;
	} div_rsp_t;

endpackage

>>> sv/casd_intf.sv
// transaction channel interfaces: request, result and config write
// no dependencies
interface casd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  context_req;
	logic [8:0]  table_index;
	logic [15:0] table_value;
	logic [31:0] next_bits;
	modport source (output valid, kind, context_req, table_index, table_value, next_bits,
		input ready);
	modport sink (input valid, kind, context_req, table_index, table_value, next_bits,
		output ready);
endinterface

interface casd_rsp_if;
	logic       valid;
	logic       ready;
	logic [8:0] decoded_index;
	logic       is_end;
	logic [5:0] bits_used;
	logic       error;
	modport source (output valid, decoded_index, is_end, bits_used, error, input ready);
	modport sink (input valid, decoded_index, is_end, bits_used, error, output ready);
endinterface

interface casd_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> sv/casd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module casd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/casd_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on casd_pkg
module casd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  casd_pkg::div_req_t req,
	output casd_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(casd_pkg::PROD_W + 1);

	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	casd_pkg::prod_t              dvd_q;
	casd_pkg::range_t             dvs_q;
	casd_pkg::range_t             rem_q;
	logic [casd_pkg::RANGE_W:0]   trial;
	logic [casd_pkg::RANGE_W:0]   diff;
	logic                         fits;

	assign trial = {rem_q, dvd_q[casd_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(casd_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[casd_pkg::RANGE_W-1:0] : trial[casd_pkg::RANGE_W-1:0];
			dvd_q <= {dvd_q[casd_pkg::PROD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

>>> sv/context_arithmetic_symbol_decoder_top.sv
// order-1 arithmetic symbol decoder: sequencer, table ram and shared divider
// depends on casd_pkg, casd_intf, casd_ram, casd_div
//
// One request transaction yields exactly one result transaction. Kind 0 writes one word of a
// context's cumulative frequency table (position 0 holds the total), kind 1 loads the code value
// from the top of next_bits, kind 2 decodes one symbol under context_req. Writes, initialise and
// unused kinds go from S_IDLE to S_FIN and back to S_IDLE. A decode runs the shared 49-bit
// restoring divider up to three times, for target count, upper bound and lower bound (each
// a start state, 49 quotient steps and a done state), reads one table entry per cycle in the
// linear search (up to 257 entries; the ram has one read port), makes one renormalisation
// shift per cycle (up to 32) until it stops. A decode whose row total is zero goes from S_TOT
// to S_FIN with error set. req.ready is low while an item is at work; a finished result sits
// in the output register so the next request can be taken while it waits.
// The table ram has no reset; entries must be written before they are read.
// cfg writes of eof_index are taken any time and should only be made while the block is idle.
module context_arithmetic_symbol_decoder_top (
	input logic       clk,
	input logic       arst_n,
	casd_req_if.sink  req,
	casd_rsp_if.source rsp,
	casd_cfg_if.sink  cfg
);

	localparam int W = casd_pkg::CODE_BITS;
	localparam int A = casd_pkg::ADDR_W;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_TOT    = 4'd1;
	localparam logic [3:0] S_DVT_GO = 4'd2;
	localparam logic [3:0] S_DVT    = 4'd3;
	localparam logic [3:0] S_SRCH   = 4'd4;
	localparam logic [3:0] S_MHI    = 4'd5;
	localparam logic [3:0] S_DVH_GO = 4'd6;
	localparam logic [3:0] S_DVH    = 4'd7;
	localparam logic [3:0] S_MLO    = 4'd8;
	localparam logic [3:0] S_DVL_GO = 4'd9;
	localparam logic [3:0] S_DVL    = 4'd10;
	localparam logic [3:0] S_CMP    = 4'd11;
	localparam logic [3:0] S_RNRM   = 4'd12;
	localparam logic [3:0] S_FIN    = 4'd13;

	logic [3:0] state_q;

	// decoder state
	casd_pkg::code_t low_q, high_q, code_q;
	logic [8:0]      eof_q;

	// per-item working registers
	logic [31:0]       win_q;
	logic [A-1:0]      base_q;
	casd_pkg::freq_t   total_q, prev_q, cur_q;
	casd_pkg::prod_t   mul_q, target_q;
	logic [8:0]        s_q;
	casd_pkg::code_t   lo_q, hi_q, v_q;

	// result being built, and the output register
	logic [8:0] res_sym_q;
	logic       res_end_q, res_err_q;
	logic [5:0] res_used_q;
	logic       out_valid_q;
	logic [8:0] out_sym_q;
	logic       out_end_q, out_err_q;
	logic [5:0] out_used_q;

	logic              in_take;
	logic              out_free;
	logic [A-1:0]      in_addr;
	logic              wr_ok;
	logic [A-1:0]      rd_addr;
	casd_pkg::freq_t   rdata;
	casd_pkg::range_t  range_w;
	casd_pkg::code_t   diff_w;
	casd_pkg::div_req_t dreq;
	casd_pkg::div_rsp_t drsp;

	// renormalisation step
	logic            rn_go;
	casd_pkg::code_t rn_sub, rn_lo, rn_hi, rn_v;

	assign in_take  = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;
	assign out_free = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;

	assign in_addr = A'(req.context_req * casd_pkg::ROW_LEN) + A'(req.table_index);
	assign wr_ok   = ({1'b0, req.context_req} < 9'(casd_pkg::NUM_CONTEXTS))
		&& (req.table_index <= 9'(casd_pkg::NUM_SYMBOLS));

	assign range_w = {1'b0, high_q} - {1'b0, low_q} + 1'b1;
	assign diff_w  = code_q - low_q;

	// table read address: row total on accept, then walk the row
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = A'(req.context_req * casd_pkg::ROW_LEN);
			S_DVT:   rd_addr = base_q + A'(1);
			default: rd_addr = base_q + A'(s_q) + A'(1);
		endcase
	end

	casd_ram #(
		.WIDTH (casd_pkg::FREQ_BITS),
		.DEPTH (casd_pkg::TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (in_take && req.kind == casd_pkg::KIND_WRITE && wr_ok),
		.waddr (in_addr),
		.wdata (req.table_value[casd_pkg::FREQ_BITS-1:0]),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// shared divider: target uses range as divisor, bounds use the total
	always_comb begin
		dreq.start    = state_q == S_DVT_GO || state_q == S_DVH_GO || state_q == S_DVL_GO;
		dreq.dividend = (state_q == S_DVT_GO) ? mul_q - 1'b1 : mul_q;
		dreq.divisor  = (state_q == S_DVT_GO) ? range_w
			: casd_pkg::RANGE_W'(total_q);
	end

	casd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// half rule, then quarter (underflow) rule, otherwise stop
	always_comb begin
		rn_go  = 1'b1;
		rn_sub = '0;
		priority if (hi_q < casd_pkg::HALF_PT) begin
			rn_sub = '0;
		end else if (lo_q >= casd_pkg::HALF_PT) begin
			rn_sub = casd_pkg::HALF_PT;
		end else if (lo_q >= casd_pkg::QTR1_PT && hi_q < casd_pkg::QTR3_PT) begin
			rn_sub = casd_pkg::QTR1_PT;
		end else begin
			rn_go = 1'b0;
		end
		rn_lo = (lo_q - rn_sub) << 1;
		rn_hi = ((hi_q - rn_sub) << 1) | W'(1);
		rn_v  = ((v_q - rn_sub) << 1) | W'(win_q[~res_used_q[4:0]]);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			low_q       <= '0;
			high_q      <= '1;
			code_q      <= '0;
			eof_q       <= casd_pkg::EOF_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				eof_q <= cfg.data;
			end
			// a new result wins over the one leaving in the same cycle
			priority if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						unique case (req.kind)
							casd_pkg::KIND_DECODE: state_q <= S_TOT;
							casd_pkg::KIND_INIT: begin
								code_q  <= req.next_bits[31 -: W];
								state_q <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_TOT:    state_q <= (rdata == '0) ? S_FIN : S_DVT_GO;
				S_DVT_GO: state_q <= S_DVT;
				S_DVT:    if (drsp.done) state_q <= S_SRCH;
				S_SRCH: begin
					if (casd_pkg::PROD_W'(rdata) > target_q) begin
						if (s_q == 9'(casd_pkg::NUM_SYMBOLS)) begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_MHI;
					end
				end
				S_MHI:    state_q <= S_DVH_GO;
				S_DVH_GO: state_q <= S_DVH;
				S_DVH:    if (drsp.done) state_q <= S_MLO;
				S_MLO:    state_q <= S_DVL_GO;
				S_DVL_GO: state_q <= S_DVL;
				S_DVL:    if (drsp.done) state_q <= S_CMP;
				S_CMP:    state_q <= (lo_q > hi_q) ? S_FIN : S_RNRM;
				S_RNRM: begin
					if (res_used_q == 6'd32 || !rn_go) begin
						low_q   <= lo_q;
						high_q  <= hi_q;
						code_q  <= v_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				win_q      <= req.next_bits;
				base_q     <= A'(req.context_req * casd_pkg::ROW_LEN);
				res_sym_q  <= '0;
				res_end_q  <= 1'b0;
				res_err_q  <= 1'b0;
				res_used_q <= (req.kind == casd_pkg::KIND_INIT) ? 6'(W) : 6'd0;
			end
			S_TOT: begin
				total_q   <= rdata;
				res_err_q <= rdata == '0;
				mul_q     <= casd_pkg::PROD_W'({1'b0, diff_w} + 1'b1)
					* casd_pkg::PROD_W'(rdata);
			end
			S_DVT: begin
				target_q <= drsp.quotient;
				prev_q   <= total_q;
				s_q      <= 9'd1;
			end
			S_SRCH: begin
				if (casd_pkg::PROD_W'(rdata) > target_q) begin
					prev_q <= rdata;
					s_q    <= s_q + 1'b1;
					if (s_q == 9'(casd_pkg::NUM_SYMBOLS)) begin
						res_err_q <= 1'b1;
					end
				end else begin
					cur_q <= rdata;
				end
			end
			S_MHI: mul_q <= casd_pkg::PROD_W'(range_w) * casd_pkg::PROD_W'(prev_q);
			S_DVH: hi_q  <= low_q + drsp.quotient[W-1:0] - 1'b1;
			S_MLO: mul_q <= casd_pkg::PROD_W'(range_w) * casd_pkg::PROD_W'(cur_q);
			S_DVL: lo_q  <= low_q + drsp.quotient[W-1:0];
			S_CMP: begin
				res_sym_q <= s_q;
				res_end_q <= s_q == eof_q;
				res_err_q <= lo_q > hi_q;
				v_q       <= code_q;
			end
			S_RNRM: begin
				if (res_used_q != 6'd32 && rn_go) begin
					lo_q       <= rn_lo;
					hi_q       <= rn_hi;
					v_q        <= rn_v;
					res_used_q <= res_used_q + 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_sym_q  <= res_sym_q;
					out_end_q  <= res_end_q;
					out_err_q  <= res_err_q;
					out_used_q <= res_used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.decoded_index = out_sym_q;
	assign rsp.is_end        = out_end_q;
	assign rsp.bits_used     = out_used_q;
	assign rsp.error         = out_err_q;

endmodule

>>> sv/casd_checker.sv
// port-level checks for the arithmetic symbol decoder, bound to the top level
// depends on context_arithmetic_symbol_decoder_top
module casd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [8:0] rsp_decoded_index,
	input logic       rsp_is_end,
	input logic [5:0] rsp_bits_used
);

	// one item at a time: after a request transaction the block is busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is at work");

	// end of stream is only flagged on a real symbol
	a_end_sym: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_end |-> rsp_decoded_index != 9'd0)
		else $error("end flag without a symbol");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_bits_used <= 6'd32 && rsp_decoded_index <= 9'd257)
		else $error("result field out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_decoded_index))
		else $error("stalled result changed");

endmodule

bind context_arithmetic_symbol_decoder_top casd_checker u_casd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_decoded_index (rsp.decoded_index),
	.rsp_is_end        (rsp.is_end),
	.rsp_bits_used     (rsp.bits_used)
);

>>> bench/tb_context_arithmetic_symbol_decoder_top.sv
// self-checking bench for the order-1 arithmetic symbol decoder
// depends on casd_pkg, casd_intf and the decoder top level
`timescale 1ns / 100ps

module tb_context_arithmetic_symbol_decoder_top;

	// request kind the block ignores
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  context_req;
		logic [8:0]  table_index;
		logic [15:0] table_value;
		logic [31:0] next_bits;
	} request_t;

	typedef struct packed {
		logic [8:0] decoded_index;
		logic       is_end;
		logic [5:0] bits_used;
		logic       error;
	} decoded_t;

	// idling regimes: sender busy / receiver busy, swapped, none
	typedef enum int {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_t;

	logic clk;
	logic arst_n;

	casd_req_if req();
	casd_rsp_if rsp();
	casd_cfg_if cfg();

	context_arithmetic_symbol_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source),
		.cfg(cfg.sink)
	);

	// predictor state
	logic [31:0] pred_low, pred_high, pred_code;
	logic [8:0]  pred_eof;
	logic [15:0] freq_mirror [casd_pkg::NUM_CONTEXTS][casd_pkg::ROW_LEN];
	bit          row_loaded [casd_pkg::NUM_CONTEXTS];

	request_t pending_requests[$];
	decoded_t expected_symbols[$];

	int         mismatch_count;
	int         sent_count, checked_count, decode_count, end_count, error_count;
	idle_mode_t idle_mode;
	bit         recv_hold;
	bit         hold_go;
	bit         req_taken;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// work out the result of one request and advance the predictor state
	function automatic decoded_t predict_symbol(request_t r);
		decoded_t o;
		logic [32:0] span;
		logic [31:0] diff, lo, hi, v;
		logic [63:0] target, total, lo_w, hi_w;
		int s;
		o = '0;
		case (r.kind)
			casd_pkg::KIND_WRITE: begin
				if (r.table_index <= casd_pkg::NUM_SYMBOLS)
					freq_mirror[r.context_req][r.table_index] = r.table_value;
			end
			casd_pkg::KIND_INIT: begin
				pred_code = r.next_bits;
				o.bits_used = 6'd32;
			end
			casd_pkg::KIND_DECODE: begin
				total = 64'(freq_mirror[r.context_req][0]);
				if (total == 0) begin
					o.error = 1'b1;
				end else begin
					span = {1'b0, pred_high} - {1'b0, pred_low} + 33'd1;
					diff = pred_code - pred_low;
					target = (({32'd0, diff} + 64'd1) * total - 64'd1) / span;
					s = 1;
					while (s <= casd_pkg::NUM_SYMBOLS
						&& freq_mirror[r.context_req][s] > target)
						s++;
					if (s > casd_pkg::NUM_SYMBOLS) begin
						o.error = 1'b1;
					end else begin
						hi_w = pred_low + (span * freq_mirror[r.context_req][s-1]) / total - 1;
						lo_w = pred_low + (span * freq_mirror[r.context_req][s]) / total;
						hi = hi_w[31:0];
						lo = lo_w[31:0];
						o.decoded_index = s[8:0];
						if (lo > hi) begin
							o.error = 1'b1;
						end else begin
							v = pred_code;
							while (o.bits_used < 32) begin
								if (hi < casd_pkg::HALF_PT) begin
								end else if (lo >= casd_pkg::HALF_PT) begin
									v -= casd_pkg::HALF_PT;
									lo -= casd_pkg::HALF_PT;
									hi -= casd_pkg::HALF_PT;
								end else if (lo >= casd_pkg::QTR1_PT
									&& hi < casd_pkg::QTR3_PT) begin
									v -= casd_pkg::QTR1_PT;
									lo -= casd_pkg::QTR1_PT;
									hi -= casd_pkg::QTR1_PT;
								end else begin
									break;
								end
								lo = lo << 1;
								hi = (hi << 1) | 32'd1;
								v = (v << 1) | 32'(r.next_bits[31 - o.bits_used]);
								o.bits_used++;
							end
							pred_low = lo;
							pred_high = hi;
							pred_code = v;
						end
						o.is_end = (o.decoded_index == pred_eof);
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", checked_count, what, got, want);
		mismatch_count++;
	endtask

	// driver: offers the oldest pending request, moves on once it was taken
	always @(negedge clk or negedge arst_n) begin
		request_t r;
		bit offer;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.kind <= '0;
			req.context_req <= '0;
			req.table_index <= '0;
			req.table_value <= '0;
			req.next_bits <= '0;
		end else begin
			offer = idle_mode == IDLE_SEND_LIGHT ? ($urandom_range(99) >= 35) :
				idle_mode == IDLE_RECV_LIGHT ? ($urandom_range(99) >= 61) : 1'b1;
			if (!req.valid || req_taken) begin
				if (pending_requests.size() > 0 && offer) begin
					r = pending_requests.pop_front();
					req.valid <= 1'b1;
					{req.kind, req.context_req, req.table_index, req.table_value,
						req.next_bits} <= r;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// acceptance is seen at the rising edge, prediction happens in order there
	always @(posedge clk) begin
		req_taken = arst_n && req.valid && req.ready;
		if (req_taken) begin
			expected_symbols.push_back(predict_symbol({req.kind, req.context_req,
				req.table_index, req.table_value, req.next_bits}));
			sent_count++;
			if (req.kind == casd_pkg::KIND_DECODE) decode_count++;
		end
	end

	// receiver ready, with random stalls and the long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else if (recv_hold)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= idle_mode == IDLE_SEND_LIGHT ? ($urandom_range(99) >= 61) :
				idle_mode == IDLE_RECV_LIGHT ? ($urandom_range(99) >= 35) : 1'b1;
	end

	// long receiver hold-off, timed here while the sender keeps offering
	initial begin
		wait (hold_go);
		recv_hold = 1'b1;
		repeat (400) @(posedge clk);
		recv_hold = 1'b0;
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_symbols.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				want = expected_symbols.pop_front();
				if (rsp.decoded_index !== want.decoded_index)
					report_mismatch("decoded_index", int'(rsp.decoded_index),
						int'(want.decoded_index));
				if (rsp.is_end !== want.is_end)
					report_mismatch("is_end", int'(rsp.is_end), int'(want.is_end));
				if (rsp.bits_used !== want.bits_used)
					report_mismatch("bits_used", int'(rsp.bits_used), int'(want.bits_used));
				if (rsp.error !== want.error)
					report_mismatch("error", int'(rsp.error), int'(want.error));
				if (want.is_end) end_count++;
				if (want.error) error_count++;
			end
			checked_count++;
		end
	end

	function automatic request_t make_req(logic [1:0] k, logic [7:0] c, logic [8:0] i,
		logic [15:0] w, logic [31:0] b);
		return '{kind: k, context_req: c, table_index: i, table_value: w, next_bits: b};
	endfunction

	// load a full row: non-increasing cumulative counts ending at zero
	task automatic queue_table_row(int ctx, int total, int nsym);
		int f;
		pending_requests.push_back(make_req(casd_pkg::KIND_WRITE, 8'(ctx), 9'd0,
			16'(total), '0));
		for (int s = 1; s <= casd_pkg::NUM_SYMBOLS; s++) begin
			f = s >= nsym ? 0 : total - (total * s) / nsym;
			if (f < 0) f = 0;
			pending_requests.push_back(make_req(casd_pkg::KIND_WRITE, 8'(ctx), 9'(s),
				16'(f), '0));
		end
		row_loaded[ctx] = 1'b1;
	endtask

	task automatic drain_all();
		while (pending_requests.size() > 0 || expected_symbols.size() > 0 || req.valid)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic write_eof(logic [8:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		pred_eof = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [7:0] loaded_context();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (!row_loaded[c]);
		return c;
	endfunction

	initial begin
		request_t r;
		int pick;
		cfg.valid = 1'b0;
		cfg.data = '0;
		req.valid = 1'b0;
		rsp.ready = 1'b0;
		mismatch_count = 0;
		sent_count = 0; checked_count = 0; decode_count = 0; end_count = 0; error_count = 0;
		idle_mode = IDLE_SEND_LIGHT;
		pred_low = '0;
		pred_high = '1;
		pred_code = '0;
		pred_eof = casd_pkg::EOF_RESET;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_eof(9'd1);

		// directed: rows, init, decodes, and special cases
		queue_table_row(0, 65535, 257);
		queue_table_row(255, 1, 2);
		queue_table_row(7, 1000, 3);
		// zero total row
		pending_requests.push_back(make_req(casd_pkg::KIND_WRITE, 8'd9, 9'd0, 16'd0, '0));
		// row whose search always overruns
		pending_requests.push_back(make_req(casd_pkg::KIND_WRITE, 8'd3, 9'd0, 16'd10, '0));
		for (int s = 1; s <= casd_pkg::NUM_SYMBOLS; s++)
			pending_requests.push_back(make_req(casd_pkg::KIND_WRITE, 8'd3, 9'(s),
				16'hffff, '0));
		// position past the row, ignored
		pending_requests.push_back(make_req(casd_pkg::KIND_WRITE, 8'd5, 9'd300, 16'h1234, '0));
		pending_requests.push_back(make_req(KIND_SPARE, 8'hff, 9'h1ff, 16'hffff, '1));
		pending_requests.push_back(make_req(casd_pkg::KIND_INIT, 8'd0, 9'd0, 16'd0,
			32'hffffffff));
		pending_requests.push_back(make_req(casd_pkg::KIND_DECODE, 8'd0, 9'd0, 16'd0, 32'h0));
		pending_requests.push_back(make_req(casd_pkg::KIND_DECODE, 8'd255, 9'd0, 16'd0, '1));
		pending_requests.push_back(make_req(casd_pkg::KIND_DECODE, 8'd9, 9'd0, 16'd0, '1));
		pending_requests.push_back(make_req(casd_pkg::KIND_DECODE, 8'd3, 9'd0, 16'd0, '1));
		pending_requests.push_back(make_req(casd_pkg::KIND_INIT, 8'd0, 9'd0, 16'd0, 32'h0));
		pending_requests.push_back(make_req(casd_pkg::KIND_DECODE, 8'd7, 9'd0, 16'd0,
			32'haaaa5555));
		pending_requests.push_back(make_req(casd_pkg::KIND_DECODE, 8'd0, 9'd0, 16'd0,
			32'h5555aaaa));
		row_loaded[9] = 1'b1;
		row_loaded[3] = 1'b1;
		drain_all();

		// long hold-off: the block fills and back-pressures its input
		for (int i = 0; i < 6; i++)
			pending_requests.push_back(make_req(casd_pkg::KIND_INIT, 8'd0, 9'd0, 16'd0,
				$urandom()));
		hold_go = 1'b1;
		@(posedge clk);
		wait (!recv_hold);
		drain_all();

		for (int phase = 0; phase < 3; phase++) begin
			idle_mode = idle_mode_t'(phase);
			write_eof(phase == 0 ? 9'd257 : phase == 1 ? 9'd2 : 9'($urandom_range(1, 40)));
			// first phase only: one fresh row with random shape, small symbol counts mostly
			if (phase == 0)
				queue_table_row($urandom_range(10, 254), $urandom_range(1, 65535),
					$urandom_range(0, 9) == 0 ? 257 : $urandom_range(2, 40));
			pending_requests.push_back(make_req(casd_pkg::KIND_INIT, 8'd0, 9'd0, 16'd0,
				$urandom()));
			for (int n = 0; n < 215; n++) begin
				pick = $urandom_range(99);
				if (pick < 85)
					r = make_req(casd_pkg::KIND_DECODE, loaded_context(), 9'($urandom()),
						16'($urandom()), $urandom());
				else if (pick < 90)
					r = make_req(casd_pkg::KIND_INIT, 8'($urandom()), 9'($urandom()),
						16'($urandom()), $urandom());
				else if (pick < 95)
					r = make_req(casd_pkg::KIND_WRITE, 8'($urandom()),
						9'($urandom_range(258, 511)), 16'($urandom()), $urandom());
				else
					r = make_req(KIND_SPARE, 8'($urandom()), 9'($urandom()),
						16'($urandom()), $urandom());
				pending_requests.push_back(r);
			end
			drain_all();
		end

		$display("covered %0d requests, %0d decodes, %0d end markers, %0d error results",
			sent_count, decode_count, end_count, error_count);
		$display("stall regimes on both sides plus one long receiver hold-off were exercised");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
sv/casd_pkg.sv
sv/casd_intf.sv
sv/casd_ram.sv
sv/casd_div.sv
sv/context_arithmetic_symbol_decoder_top.sv
sv/casd_checker.sv
bench/tb_context_arithmetic_symbol_decoder_top.sv
